// File: hdl/hafp_pkg.sv
package hafp_pkg;

  localparam int unsigned CORDIC_STAGES   = 14;
  localparam int unsigned COORD_FRAC_BITS = 4;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned HEAD_W  = 16;
  localparam int unsigned ALPHA_W = 14;
  // x/y carry 16 extra fraction bits; sqrt(2) times the ~1.65 gain needs two more bits,
  // plus sign
  localparam int unsigned XW      = COORD_W + 16 + 3;
  localparam int unsigned ZW      = 25;

  localparam int unsigned MQ_DEPTH = 4;
  localparam int unsigned MQ_AW    = $clog2(MQ_DEPTH);
  localparam int unsigned OQ_DEPTH = 32;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);

  localparam logic [HEAD_W-1:0]  ANG_0   = HEAD_W'(0);
  localparam logic [HEAD_W-1:0]  ANG_90  = HEAD_W'(11520);
  localparam logic [HEAD_W-1:0]  ANG_180 = HEAD_W'(23040);
  localparam logic [HEAD_W-1:0]  ANG_270 = HEAD_W'(34560);
  localparam logic [HEAD_W-1:0]  ANG_360 = HEAD_W'(46080);
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(11520);

  typedef enum logic [3:0] {
    DIR_NONE = 4'd0,
    DIR_Q1   = 4'd1,
    DIR_Q2   = 4'd2,
    DIR_Q3   = 4'd3,
    DIR_Q4   = 4'd4,
    DIR_PX   = 4'd5,
    DIR_PY   = 4'd6,
    DIR_NX   = 4'd7,
    DIR_NY   = 4'd8
  } dir_e;

  typedef struct packed {
    logic [COORD_W-1:0] adx;
    logic [COORD_W-1:0] ady;
    dir_e               code;
  } mid_item_t;

  typedef struct packed {
    logic signed [ZW-1:0] z;
    dir_e                 code;
  } cordic_res_t;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    dir_e              code;
  } out_item_t;

  // atan(2^-i) in degrees, Q16, rounded
  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned idx);
    logic signed [ZW-1:0] t;
    unique case (idx)
      0:  t = 25'sd2949120;
      1:  t = 25'sd1740967;
      2:  t = 25'sd919879;
      3:  t = 25'sd466945;
      4:  t = 25'sd234379;
      5:  t = 25'sd117304;
      6:  t = 25'sd58666;
      7:  t = 25'sd29335;
      8:  t = 25'sd14668;
      9:  t = 25'sd7334;
      10: t = 25'sd3667;
      11: t = 25'sd1833;
      12: t = 25'sd917;
      13: t = 25'sd458;
      14: t = 25'sd229;
      15: t = 25'sd115;
      16: t = 25'sd57;
      17: t = 25'sd29;
      18: t = 25'sd14;
      19: t = 25'sd7;
      20: t = 25'sd4;
      21: t = 25'sd2;
      22: t = 25'sd1;
      default: t = 25'sd0;
    endcase
    return t;
  endfunction

endpackage

// File: hdl/heading_angle_from_points.sv
// Heading of the vector from a start point to a target point, in degrees
// (Q9.7, 0 to under 360, y pointing down), plus a direction code.
//
// Input channel: drive pos_x_i/pos_y_i/target_x_i/target_y_i and push; a
// transaction happens at a clock edge with push high and full low.
// Result channel: while empty is low the oldest result sits on
// heading_deg_o/direction_code_o; it is taken at an edge with pop high.
// Config channel: cfg_data_i[0] is rotation_enable, written at an edge with
// cfg_valid_i high (cfg_ready_o is always high). Write it only when idle.
//
// Between the accepting edge and empty going low an item passes the classify
// queue, the 14-stage CORDIC pipeline and the final placement stage.
// Throughput: one transaction per cycle in each direction while full and empty stay low.
// A stalled receiver fills the 32-entry output queue; the CORDIC issue is
// credit gated, so the input side keeps accepting until the 4-entry
// classify queue fills, then full goes high. No result is dropped.
// Reset: queues empty, rotation_enable set to 1.
module heading_angle_from_points (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [hafp_pkg::COORD_W-1:0] pos_x_i,
  input  logic [hafp_pkg::COORD_W-1:0] pos_y_i,
  input  logic [hafp_pkg::COORD_W-1:0] target_x_i,
  input  logic [hafp_pkg::COORD_W-1:0] target_y_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [hafp_pkg::HEAD_W-1:0]  heading_deg_o,
  output logic [3:0]                   direction_code_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_data_i
);
  import hafp_pkg::*;

  mid_item_t fr_item, mq_item;
  logic      mq_empty, mq_pop;
  logic      rotation_enable_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_enable_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rotation_enable_q <= cfg_data_i;
    end
  end

  hafp_front u_front (
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .target_x_i (target_x_i),
    .target_y_i (target_y_i),
    .item_o     (fr_item)
  );

  hafp_mid_queue u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fr_item),
    .full_o  (full),
    .pop_i   (mq_pop),
    .item_o  (mq_item),
    .empty_o (mq_empty)
  );

  hafp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mq_empty_i        (mq_empty),
    .mq_item_i         (mq_item),
    .mq_pop_o          (mq_pop),
    .rotation_enable_i (rotation_enable_q),
    .empty_o           (empty),
    .pop_i             (pop),
    .heading_deg_o     (heading_deg_o),
    .direction_code_o  (direction_code_o)
  );

endmodule

// File: hdl/hafp_front.sv
module hafp_front (
  input  logic [hafp_pkg::COORD_W-1:0] pos_x_i,
  input  logic [hafp_pkg::COORD_W-1:0] pos_y_i,
  input  logic [hafp_pkg::COORD_W-1:0] target_x_i,
  input  logic [hafp_pkg::COORD_W-1:0] target_y_i,
  output hafp_pkg::mid_item_t          item_o
);
  import hafp_pkg::*;

  logic signed [COORD_W:0] dx, dy;
  logic                    dx_pos, dx_neg, dy_pos, dy_neg;

  assign dx = signed'({1'b0, target_x_i}) - signed'({1'b0, pos_x_i});
  assign dy = signed'({1'b0, target_y_i}) - signed'({1'b0, pos_y_i});

  assign dx_neg = dx[COORD_W];
  assign dy_neg = dy[COORD_W];
  assign dx_pos = !dx_neg && (dx != '0);
  assign dy_pos = !dy_neg && (dy != '0);

  always_comb begin
    item_o.adx = dx_neg ? COORD_W'(-dx) : dx[COORD_W-1:0];
    item_o.ady = dy_neg ? COORD_W'(-dy) : dy[COORD_W-1:0];
    if (dx_pos && dy_pos) begin
      item_o.code = DIR_Q1;
    end else if (dx_neg && dy_pos) begin
      item_o.code = DIR_Q2;
    end else if (dx_neg && dy_neg) begin
      item_o.code = DIR_Q3;
    end else if (dx_pos && dy_neg) begin
      item_o.code = DIR_Q4;
    end else if (dx_pos) begin
      item_o.code = DIR_PX;
    end else if (dy_pos) begin
      item_o.code = DIR_PY;
    end else if (dx_neg) begin
      item_o.code = DIR_NX;
    end else if (dy_neg) begin
      item_o.code = DIR_NY;
    end else begin
      item_o.code = DIR_NONE;
    end
  end

endmodule

// File: hdl/hafp_mid_queue.sv
module hafp_mid_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hafp_pkg::mid_item_t item_i,
  output logic                full_o,
  input  logic                pop_i,
  output hafp_pkg::mid_item_t item_o,
  output logic                empty_o
);
  import hafp_pkg::*;

  mid_item_t        mem_q [MQ_DEPTH];
  logic [MQ_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [MQ_AW:0]   cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == (MQ_AW+1)'(MQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + MQ_AW'(1) : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + MQ_AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (MQ_AW+1)'(wr_en) - (MQ_AW+1)'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (MQ_AW+1)'(MQ_DEPTH))
    else $error("mid queue count out of range");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == cnt_q[MQ_AW-1:0])
    else $error("mid queue pointers disagree with count");
  a_push_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !rd_en) |=> (cnt_q == $past(cnt_q) + (MQ_AW+1)'(1)))
    else $error("mid queue lost a push");
`endif

endmodule

// File: hdl/hafp_cordic.sv
module hafp_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_vld_i,
  input  hafp_pkg::mid_item_t   in_item_i,
  output logic                  out_vld_o,
  output hafp_pkg::cordic_res_t out_res_o
);
  import hafp_pkg::*;

  logic signed [XW-1:0] x_q [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_q [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_q [CORDIC_STAGES+1];
  dir_e                 code_q [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CORDIC_STAGES-1:0], in_vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= signed'(XW'({in_item_i.adx, 16'h0000}));
    y_q[0]    <= signed'(XW'({in_item_i.ady, 16'h0000}));
    z_q[0]    <= '0;
    code_q[0] <= in_item_i.code;
  end

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    logic signed [XW-1:0] xs, ys;
    assign xs = x_q[s] >>> s;
    assign ys = y_q[s] >>> s;

    always_ff @(posedge clk_i) begin
      if (!y_q[s][XW-1]) begin
        x_q[s+1] <= x_q[s] + ys;
        y_q[s+1] <= y_q[s] - xs;
        z_q[s+1] <= z_q[s] + atan_q16(s);
      end else begin
        x_q[s+1] <= x_q[s] - ys;
        y_q[s+1] <= y_q[s] + xs;
        z_q[s+1] <= z_q[s] - atan_q16(s);
      end
      code_q[s+1] <= code_q[s];
    end
  end

  assign out_vld_o      = vld_q[CORDIC_STAGES];
  assign out_res_o.z    = z_q[CORDIC_STAGES];
  assign out_res_o.code = code_q[CORDIC_STAGES];

endmodule

// File: hdl/hafp_back.sv
module hafp_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         mq_empty_i,
  input  hafp_pkg::mid_item_t          mq_item_i,
  output logic                         mq_pop_o,
  input  logic                         rotation_enable_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [hafp_pkg::HEAD_W-1:0]  heading_deg_o,
  output logic [3:0]                   direction_code_o
);
  import hafp_pkg::*;

  logic             cor_vld;
  cordic_res_t      cor_res;
  logic             issue, deq;
  logic [OQ_AW:0]   cred_q, cred_d;

  logic signed [ZW-1:0] z_rnd;
  logic [ALPHA_W-1:0]   alpha;
  logic [HEAD_W-1:0]    alpha_w, head_raw, head;

  logic        fin_vld_q;
  out_item_t   fin_q;

  out_item_t        mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OQ_AW:0]   ocnt_q, ocnt_d;
  out_item_t        rd_item;

  // credits cover every item from issue until it leaves the output queue
  assign issue    = !mq_empty_i && (cred_q < (OQ_AW+1)'(OQ_DEPTH));
  assign mq_pop_o = issue;
  assign deq      = pop_i && !empty_o;
  assign cred_d   = cred_q + (OQ_AW+1)'(issue) - (OQ_AW+1)'(deq);

  hafp_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (issue),
    .in_item_i (mq_item_i),
    .out_vld_o (cor_vld),
    .out_res_o (cor_res)
  );

  always_comb begin
    z_rnd = (cor_res.z + signed'(ZW'(256))) >>> 9;
    if (z_rnd[ZW-1]) begin
      alpha = '0;
    end else if (z_rnd > signed'(ZW'(ALPHA_MAX))) begin
      alpha = ALPHA_MAX;
    end else begin
      alpha = z_rnd[ALPHA_W-1:0];
    end
    alpha_w = HEAD_W'(alpha);
    unique case (cor_res.code)
      DIR_Q1:  head_raw = alpha_w;
      DIR_Q2:  head_raw = ANG_180 - alpha_w;
      DIR_Q3:  head_raw = ANG_180 + alpha_w;
      DIR_Q4:  head_raw = ANG_360 - alpha_w;
      DIR_PY:  head_raw = ANG_90;
      DIR_NX:  head_raw = ANG_180;
      DIR_NY:  head_raw = ANG_270;
      default: head_raw = ANG_0;
    endcase
    if (head_raw >= ANG_360 || !rotation_enable_i) begin
      head = ANG_0;
    end else begin
      head = head_raw;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q.head <= head;
    fin_q.code <= cor_res.code;
    if (fin_vld_q) begin
      mem_q[wr_ptr_q] <= fin_q;
    end
  end

  assign ocnt_d  = ocnt_q + (OQ_AW+1)'(fin_vld_q) - (OQ_AW+1)'(deq);
  assign empty_o = (ocnt_q == '0);
  assign rd_item = mem_q[rd_ptr_q];
  assign heading_deg_o    = rd_item.head;
  assign direction_code_o = rd_item.code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q    <= '0;
      fin_vld_q <= 1'b0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      ocnt_q    <= '0;
    end else begin
      cred_q    <= cred_d;
      fin_vld_q <= cor_vld;
      ocnt_q    <= ocnt_d;
      if (fin_vld_q) begin
        wr_ptr_q <= wr_ptr_q + OQ_AW'(1);
      end
      if (deq) begin
        rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cred_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cred_q <= (OQ_AW+1)'(OQ_DEPTH))
    else $error("credit count out of range");
  a_ocnt_le_cred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= cred_q)
    else $error("output queue holds more than issued");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_vld_q |-> (ocnt_q < (OQ_AW+1)'(OQ_DEPTH)) || deq)
    else $error("output queue overflow");
`endif

endmodule

// File: tb/sv/heading_tb_pkg.sv
package heading_tb_pkg;

  import hafp_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
  } point_pair_t;

  class heading_scoreboard;

    out_item_t heading_q[$];
    bit        rot_en;
    int        errors;

    function new();
      rot_en = 1'b1;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endfunction

    function void set_enable(bit en);
      rot_en = en;
    endfunction

    function int pending();
      return heading_q.size();
    endfunction

    // atan(2^-i) in degrees, Q16
    function longint atan_deg(int i);
      longint t;
      case (i)
        0:  t = 2949120;
        1:  t = 1740967;
        2:  t = 919879;
        3:  t = 466945;
        4:  t = 234379;
        5:  t = 117304;
        6:  t = 58666;
        7:  t = 29335;
        8:  t = 14668;
        9:  t = 7334;
        10: t = 3667;
        11: t = 1833;
        12: t = 917;
        13: t = 458;
        14: t = 229;
        15: t = 115;
        16: t = 57;
        17: t = 29;
        18: t = 14;
        19: t = 7;
        20: t = 4;
        21: t = 2;
        22: t = 1;
        default: t = 0;
      endcase
      return t;
    endfunction

    function int ref_alpha(longint adx, longint ady);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      x = adx * 65536;
      y = ady * 65536;
      z = 0;
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_deg(i);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_deg(i);
        end
      end
      z = (z + 256) >>> 9;
      if (z < 0) z = 0;
      if (z > longint'(ANG_90)) z = longint'(ANG_90);
      return int'(z);
    endfunction

    function out_item_t heading_of(point_pair_t p);
      out_item_t r;
      int        dx;
      int        dy;
      int        h;
      int        a;
      dx = int'(p.tx) - int'(p.px);
      dy = int'(p.ty) - int'(p.py);
      h  = 0;
      if (dx > 0 && dy > 0)      r.code = DIR_Q1;
      else if (dx < 0 && dy > 0) r.code = DIR_Q2;
      else if (dx < 0 && dy < 0) r.code = DIR_Q3;
      else if (dx > 0 && dy < 0) r.code = DIR_Q4;
      else if (dx > 0)           r.code = DIR_PX;
      else if (dy > 0)           r.code = DIR_PY;
      else if (dx < 0)           r.code = DIR_NX;
      else if (dy < 0)           r.code = DIR_NY;
      else                       r.code = DIR_NONE;
      case (r.code)
        DIR_Q1, DIR_Q2, DIR_Q3, DIR_Q4: begin
          a = ref_alpha(longint'(dx < 0 ? -dx : dx), longint'(dy < 0 ? -dy : dy));
          case (r.code)
            DIR_Q1:  h = a;
            DIR_Q2:  h = int'(ANG_180) - a;
            DIR_Q3:  h = int'(ANG_180) + a;
            default: h = int'(ANG_360) - a;
          endcase
          if (h >= int'(ANG_360)) h = 0;
        end
        DIR_PY:  h = int'(ANG_90);
        DIR_NX:  h = int'(ANG_180);
        DIR_NY:  h = int'(ANG_270);
        default: h = 0;
      endcase
      if (!rot_en) h = 0;
      r.head = h[HEAD_W-1:0];
      return r;
    endfunction

    function void note_input(point_pair_t p);
      heading_q.push_back(heading_of(p));
    endfunction

    function void check_result(logic [HEAD_W-1:0] head, logic [3:0] code);
      out_item_t exp_item;
      if (heading_q.size() == 0) begin
        report($sformatf("result head=%0d code=%0d with nothing outstanding", head, code));
        return;
      end
      exp_item = heading_q.pop_front();
      if (head !== exp_item.head)
        report($sformatf("heading_deg got %0d exp %0d", head, exp_item.head));
      if (code !== exp_item.code)
        report($sformatf("direction_code got %0d exp %0d", code, exp_item.code));
    endfunction

  endclass

endpackage

// File: tb/sv/heading_angle_from_points_tb.sv
module heading_angle_from_points_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import hafp_pkg::*;
  import heading_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 40;
  localparam int LONG_HOLD   = 400;

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [COORD_W-1:0] pos_x_i;
  logic [COORD_W-1:0] pos_y_i;
  logic [COORD_W-1:0] target_x_i;
  logic [COORD_W-1:0] target_y_i;
  logic               empty;
  logic               pop;
  logic [HEAD_W-1:0]  heading_deg_o;
  logic [3:0]         direction_code_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_data_i;

  heading_scoreboard sb = new();

  bit snd_idle = 1'b1;
  bit rcv_idle = 1'b1;
  int hold_cycles = 0;
  int cycles = 0;

  heading_angle_from_points dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .target_x_i       (target_x_i),
    .target_y_i       (target_y_i),
    .empty            (empty),
    .pop              (pop),
    .heading_deg_o    (heading_deg_o),
    .direction_code_o (direction_code_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // transaction monitor: values read here are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_enable(cfg_data_i);
      if (push && !full) sb.note_input('{pos_x_i, pos_y_i, target_x_i, target_y_i});
      if (pop && !empty) sb.check_result(heading_deg_o, direction_code_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic point_pair_t pp(int px, int py, int tx, int ty);
    point_pair_t p;
    p.px = px[15:0];
    p.py = py[15:0];
    p.tx = tx[15:0];
    p.ty = ty[15:0];
    return p;
  endfunction

  function automatic logic [15:0] pick_edge();
    case ($urandom_range(0, 2))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic point_pair_t rand_pair();
    point_pair_t p;
    int          d;
    p = point_pair_t'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      4, 5: begin
        p.tx = p.px + 16'($signed($urandom_range(0, 16)) - 8);
        p.ty = p.py + 16'($signed($urandom_range(0, 16)) - 8);
      end
      6: begin
        if ($urandom_range(0, 1)) p.tx = p.px;
        else p.ty = p.py;
      end
      7: begin
        case ($urandom_range(0, 2))
          0: p = pp(p.px, p.py, p.px, p.py);
          1: p.tx = p.px + 16'($signed($urandom_range(0, 4)) - 2);
          default: p.ty = p.py + 16'($signed($urandom_range(0, 4)) - 2);
        endcase
      end
      8: p = '{pick_edge(), pick_edge(), pick_edge(), pick_edge()};
      9: begin
        d = $urandom_range(1, 20000);
        p.tx = p.px + 16'($urandom_range(0, 1) ? d : -d);
        p.ty = p.py + 16'($urandom_range(0, 1) ? d : -d);
      end
      default: ;
    endcase
    return p;
  endfunction

  // all driving tasks start and end just after a falling edge
  task automatic send(point_pair_t p);
    int gap;
    gap = snd_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push       <= 1'b1;
    pos_x_i    <= p.px;
    pos_y_i    <= p.py;
    target_x_i <= p.tx;
    target_y_i <= p.ty;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic send_random(int n);
    repeat (n) send(rand_pair());
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_enable(bit en);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= en;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      gap = rcv_idle ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      @(negedge clk_i);
    end
  end

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    pos_x_i     = '0;
    pos_y_i     = '0;
    target_x_i  = '0;
    target_y_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_enable(1'b1);

    // directed: coincident, axes, quadrant extremes, 45 degrees, wrap at 360
    send(pp(0, 0, 0, 0));
    send(pp('hffff, 'hffff, 'hffff, 'hffff));
    send(pp(0, 5, 'hffff, 5));
    send(pp('hffff, 0, 0, 0));
    send(pp(0, 0, 0, 'hffff));
    send(pp(7, 'hffff, 7, 0));
    send(pp(0, 0, 'hffff, 'hffff));
    send(pp(0, 0, 'hffff, 1));
    send(pp(0, 0, 1, 'hffff));
    send(pp('hffff, 0, 0, 'hffff));
    send(pp('hffff, 0, 0, 1));
    send(pp('hffff, 'hffff, 0, 0));
    send(pp(1, 'hffff, 0, 0));
    send(pp(0, 'hffff, 'hffff, 0));
    send(pp(0, 1, 'hffff, 0));
    send(pp(100, 100, 101, 101));
    send(pp(100, 100, 99, 101));
    send(pp('h8000, 'h8000, 'h7fff, 'h7fff));
    drain();

    write_enable(1'b0);
    send(pp(0, 0, 'hffff, 'hffff));
    send(pp(0, 1, 'hffff, 0));
    send(pp(3, 3, 3, 3));
    send(pp(0, 0, 0, 'hffff));
    drain();
    write_enable(1'b1);

    send_random(200);

    // receiver stalls long while the sender streams, so full must rise
    snd_idle    = 1'b0;
    hold_cycles = LONG_HOLD;
    send_random(150);
    snd_idle = 1'b1;
    drain();

    write_enable(1'b0);
    send_random(100);
    drain();
    write_enable(1'b1);

    snd_idle = 1'b0;
    rcv_idle = 1'b0;
    send_random(150);

    snd_idle = 1'b1;
    send_random(130);

    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
